// File: design/svie_pkg.sv
// Package for the stack machine execute unit: opcodes, status codes, controller types.
package svie_pkg;

  localparam int NUM_REGS_DEF   = 16;
  localparam int DATA_WORDS_DEF = 1024;
  localparam int PC_INDEX_DEF   = 15;
  localparam int SP_INDEX_DEF   = 14;
  localparam int BP_INDEX_DEF   = 13;

  localparam logic [5:0] OP_END     = 6'd0;
  localparam logic [5:0] OP_JUMP    = 6'd8;
  localparam logic [5:0] OP_JCON    = 6'd9;
  localparam logic [5:0] OP_ADD     = 6'd10;
  localparam logic [5:0] OP_SUB     = 6'd11;
  localparam logic [5:0] OP_MUL     = 6'd12;
  localparam logic [5:0] OP_DIV     = 6'd13;
  localparam logic [5:0] OP_LOAD    = 6'd14;
  localparam logic [5:0] OP_STORE   = 6'd15;
  localparam logic [5:0] OP_AND     = 6'd16;
  localparam logic [5:0] OP_OR      = 6'd17;
  localparam logic [5:0] OP_MOV     = 6'd19;
  localparam logic [5:0] OP_SET     = 6'd20;
  localparam logic [5:0] OP_EQ      = 6'd21;
  localparam logic [5:0] OP_MOD     = 6'd27;
  localparam logic [5:0] OP_SYSCALL = 6'd30;
  localparam logic [5:0] OP_BPLOAD  = 6'd31;
  localparam logic [5:0] OP_BPSTORE = 6'd32;
  localparam logic [5:0] OP_CALL    = 6'd33;
  localparam logic [5:0] OP_RET     = 6'd34;
  localparam logic [5:0] OP_PUSH    = 6'd35;
  localparam logic [5:0] OP_POP     = 6'd36;
  localparam logic [5:0] OP_ADDIM   = 6'd38;
  localparam logic [5:0] OP_SUBIM   = 6'd39;
  localparam logic [5:0] OP_RETCON  = 6'd40;
  localparam logic [5:0] OP_CALLCON = 6'd41;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_SYSCALL = 2'd2;
  localparam logic [1:0] ST_FAULT   = 2'd3;

  // controller states
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RDA   = 9'b000000100,  // read register operands
    S_CHK   = 9'b000001000,  // check indices, compute address
    S_MEM   = 9'b000010000,  // memory read/write
    S_DIV   = 9'b000100000,  // divider iterating
    S_WB    = 9'b001000000,  // register writeback
    S_WB2   = 9'b010000000,  // second register writeback
    S_OUT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic clr_step;   // advance clearing pass
    logic latch;      // capture request
    logic rd_regs;    // register operands and SP/BP/PC
    logic check;      // evaluate checks
    logic mem_go;     // do memory access
    logic div_start;
    logic wb1;
    logic wb2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic fault;
    logic needs_mem;
    logic needs_div;
    logic div_done;
    logic needs_wb2;
    logic no_wb;
  } stat_t;

endpackage

// File: design/svie_div.sv
// Radix-2 signed divider producing truncated quotient and remainder.
module svie_div import svie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, nq_r, nq_nxt, nr_r, nr_nxt;
  logic [32:0] trial;

  assign trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};

  // one quotient bit per cycle on magnitudes
  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; nq_nxt = nq_r; nr_nxt = nr_r;
    if (start) begin
      q_nxt    = dividend[31] ? (32'd0 - dividend) : dividend;
      d_nxt    = divisor[31] ? (32'd0 - divisor) : divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
      nq_nxt   = dividend[31] ^ divisor[31];
      nr_nxt   = dividend[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt; nq_r <= nq_nxt; nr_r <= nr_nxt;
  end

  assign done      = busy_r && (cnt_r == 6'd1);
  assign quotient  = nq_nxt ? (32'd0 - q_nxt) : q_nxt;
  assign remainder = nr_nxt ? (32'd0 - rem_nxt[31:0]) : rem_nxt[31:0];
endmodule

// File: design/svie_ctrl.sv
// Controller state machine sequencing one instruction through the datapath.
module svie_ctrl import svie_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t st,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    ov_nxt    = ov_r && out_stall;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_regs = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        state_nxt = S_OUT;
        if (!st.fault) begin
          if (st.needs_div) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else if (st.needs_mem) state_nxt = S_MEM;
          else if (!st.no_wb) state_nxt = S_WB;
        end
      end
      S_MEM: begin
        cmd.mem_go = 1'b1;
        state_nxt  = st.no_wb ? S_OUT : S_WB;
      end
      S_DIV: begin
        if (st.div_done) state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb1   = 1'b1;
        state_nxt = st.needs_wb2 ? S_WB2 : S_OUT;
      end
      S_WB2: begin
        cmd.wb2   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

// File: design/svie_dp.sv
// Datapath: register file, data memory, checks, ALU and result registers.
module svie_dp import svie_pkg::*; #(
  parameter int NUM_REGS   = NUM_REGS_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int PC_INDEX   = PC_INDEX_DEF,
  parameter int SP_INDEX   = SP_INDEX_DEF,
  parameter int BP_INDEX   = BP_INDEX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [5:0]  in_req_type,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_syscall_number,
  output logic signed [31:0] out_next_pc
);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int MW = $clog2(DATA_WORDS);
  localparam logic [RW-1:0] PCI = RW'(PC_INDEX % NUM_REGS);
  localparam logic [RW-1:0] SPI = RW'(SP_INDEX % NUM_REGS);
  localparam logic [RW-1:0] BPI = RW'(BP_INDEX % NUM_REGS);

  logic [31:0] rf_r [NUM_REGS];
  logic [31:0] mem_r [DATA_WORDS];

  logic [5:0]  op_r;
  logic [31:0] a_r, b_r;
  logic [31:0] ra_r, rb_r, sp_r, bp_r, pc_r, mrd_r;
  logic        aok_r, bok_r;
  logic [MW-1:0] addr_r, clr_r;
  logic        fault_r, clr_done_r;
  logic [1:0]  stat_r;
  logic [31:0] sc_r, npc_r;
  logic [31:0] quo, rem;
  logic        div_done;

  // range tests on request operands
  function automatic logic reg_ok(input logic [31:0] v);
    return !v[31] && ({1'b0, v} < 33'(NUM_REGS));
  endfunction
  function automatic logic mem_ok(input logic [32:0] v);
    return !v[32] && (v < 33'(DATA_WORDS));
  endfunction

  svie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(ra_r), .divisor(rb_r),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  // opcode class decode
  logic known, is_div, is_mem, is_stack, is_call, is_ret;
  always_comb begin
    case (op_r)
      OP_END, OP_JUMP, OP_JCON, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOAD, OP_STORE,
      OP_AND, OP_OR, OP_MOV, OP_SET, OP_EQ, OP_MOD, OP_SYSCALL, OP_BPLOAD,
      OP_BPSTORE, OP_CALL, OP_RET, OP_PUSH, OP_POP, OP_ADDIM, OP_SUBIM,
      OP_RETCON, OP_CALLCON: known = 1'b1;
      default: known = 1'b0;
    endcase
  end
  assign is_div   = (op_r == OP_DIV) || (op_r == OP_MOD);
  assign is_call  = (op_r == OP_CALL) || (op_r == OP_CALLCON);
  assign is_ret   = (op_r == OP_RET) || (op_r == OP_RETCON);
  assign is_stack = is_call || is_ret || (op_r == OP_PUSH) || (op_r == OP_POP);
  assign is_mem   = is_stack || (op_r == OP_LOAD) || (op_r == OP_STORE) ||
                    (op_r == OP_BPLOAD) || (op_r == OP_BPSTORE);

  // checks and address in CHK, from registered operands
  logic        chk_fault, chk_cond;
  logic [32:0] chk_addr;
  always_comb begin
    chk_fault = 1'b0;
    chk_cond  = 1'b1;
    chk_addr  = {1'b1, 32'd0};
    case (op_r)
      OP_END, OP_SYSCALL, OP_JUMP: ;
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_MOV, OP_EQ: chk_fault = !(aok_r && bok_r);
      OP_DIV, OP_MOD: chk_fault = !(aok_r && bok_r) || (rb_r == 32'd0) ||
        ((op_r == OP_DIV) && (ra_r == 32'h8000_0000) && (rb_r == 32'hFFFF_FFFF));
      OP_LOAD: begin
        chk_addr  = {b_r[31], b_r};
        chk_fault = !aok_r || !mem_ok(chk_addr);
      end
      OP_STORE: begin
        chk_addr  = {a_r[31], a_r};
        chk_fault = !bok_r || !mem_ok(chk_addr);
      end
      OP_JCON: begin
        chk_fault = !bok_r;
        chk_cond  = rb_r != 32'd0;
      end
      OP_SET, OP_ADDIM, OP_SUBIM: chk_fault = !aok_r;
      OP_BPLOAD: begin
        chk_addr  = {bp_r[31], bp_r} + {b_r[31], b_r};
        chk_fault = !aok_r || !mem_ok(chk_addr);
      end
      OP_BPSTORE: begin
        chk_addr  = {bp_r[31], bp_r} + {a_r[31], a_r};
        chk_fault = !bok_r || !mem_ok(chk_addr);
      end
      OP_CALL, OP_PUSH: begin
        chk_addr  = {sp_r[31], sp_r} + 33'd1;
        chk_fault = ((op_r == OP_PUSH) && !aok_r) || !mem_ok(chk_addr);
      end
      OP_RET, OP_POP: begin
        chk_addr  = {sp_r[31], sp_r};
        chk_fault = ((op_r == OP_POP) && !aok_r) || !mem_ok(chk_addr);
      end
      OP_RETCON: begin
        chk_addr  = {sp_r[31], sp_r};
        chk_cond  = ra_r != 32'd0;
        chk_fault = !aok_r || (chk_cond && !mem_ok(chk_addr));
      end
      OP_CALLCON: begin
        chk_addr  = {sp_r[31], sp_r} + 33'd1;
        chk_cond  = rb_r != 32'd0;
        chk_fault = !bok_r || (chk_cond && !mem_ok(chk_addr));
      end
      default: chk_fault = 1'b1;
    endcase
    if (!known) chk_fault = 1'b1;
  end

  assign st.clr_done  = clr_done_r;
  assign st.fault     = chk_fault;
  assign st.needs_div = is_div;
  assign st.needs_mem = is_mem && chk_cond;
  assign st.div_done  = div_done;
  assign st.needs_wb2 = is_stack;
  assign st.no_wb     = !chk_cond || (op_r == OP_END) || (op_r == OP_SYSCALL) ||
                        (op_r == OP_STORE) || (op_r == OP_BPSTORE);

  // first and second writeback targets and values
  logic [RW-1:0] wi1, wi2;
  logic [31:0]   wv1, wv2, prod;
  assign prod = ra_r * rb_r;
  always_comb begin
    wi1 = a_r[RW-1:0];
    wv1 = ra_r;
    wi2 = SPI;
    wv2 = sp_r;
    case (op_r)
      OP_ADD:   wv1 = ra_r + rb_r;
      OP_SUB:   wv1 = ra_r - rb_r;
      OP_MUL:   wv1 = prod;
      OP_AND:   wv1 = {31'd0, (ra_r != 0) && (rb_r != 0)};
      OP_OR:    wv1 = {31'd0, (ra_r != 0) || (rb_r != 0)};
      OP_MOV:   wv1 = rb_r;
      OP_EQ:    wv1 = {31'd0, ra_r == rb_r};
      OP_DIV:   wv1 = quo;
      OP_MOD:   wv1 = rem;
      OP_SET:   wv1 = b_r;
      OP_ADDIM: wv1 = ra_r + b_r;
      OP_SUBIM: wv1 = ra_r - b_r;
      OP_LOAD, OP_BPLOAD: wv1 = mrd_r;
      OP_JUMP, OP_JCON: begin
        wi1 = PCI; wv1 = a_r;
      end
      OP_CALL, OP_CALLCON: begin
        wi1 = SPI; wv1 = sp_r + 32'd1; wi2 = PCI; wv2 = a_r;
      end
      OP_PUSH: begin
        wi1 = SPI; wv1 = sp_r + 32'd1; wi2 = SPI; wv2 = sp_r + 32'd1;
      end
      OP_RET, OP_RETCON: begin
        wi1 = PCI; wv1 = mrd_r; wi2 = SPI; wv2 = sp_r - 32'd1;
      end
      OP_POP: begin
        wi1 = a_r[RW-1:0]; wv1 = mrd_r; wi2 = SPI; wv2 = 32'd0;
      end
      default: ;
    endcase
  end

  // pop and ret: SP decrement uses SP as it stands after the load
  logic [31:0] sp_now;
  assign sp_now = rf_r[SPI];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
    end else if (cmd.wb1) begin
      rf_r[wi1] <= wv1;
    end else if (cmd.wb2) begin
      rf_r[wi2] <= (op_r == OP_POP || is_ret) ? (sp_now - 32'd1) : wv2;
    end
  end

  // request capture, operand reads, check results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_req_type;
      a_r  <= in_operand_a;
      b_r  <= in_operand_b;
    end
    if (cmd.rd_regs) begin
      ra_r  <= rf_r[a_r[RW-1:0]];
      rb_r  <= rf_r[b_r[RW-1:0]];
      sp_r  <= rf_r[SPI];
      bp_r  <= rf_r[BPI];
      pc_r  <= rf_r[PCI];
      aok_r <= reg_ok(a_r);
      bok_r <= reg_ok(b_r);
    end
    if (cmd.check) begin
      addr_r  <= chk_addr[MW-1:0];
      fault_r <= chk_fault;
    end
  end

  // data memory with clearing pass after reset
  // push and call store the register as it reads after the SP bump
  logic [31:0] mwd;
  logic        mwe;
  assign mwe = cmd.mem_go && ((op_r == OP_STORE) || (op_r == OP_BPSTORE) ||
                              (op_r == OP_PUSH) || is_call);
  assign mwd = is_call ? ((PCI == SPI) ? (sp_r + 32'd1) : pc_r) :
               (op_r == OP_PUSH) ? ((a_r[RW-1:0] == SPI) ? (sp_r + 32'd1) : ra_r) :
               rb_r;
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem_r[clr_r] <= '0;
    else if (mwe) mem_r[addr_r] <= mwd;
    if (cmd.mem_go) mrd_r <= mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_r      <= clr_r + MW'(1);
      clr_done_r <= (clr_r == MW'(DATA_WORDS - 2));
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      npc_r <= rf_r[PCI];
      sc_r  <= '0;
      if (fault_r) stat_r <= ST_FAULT;
      else if (op_r == OP_END) stat_r <= ST_HALT;
      else if (op_r == OP_SYSCALL) begin
        stat_r <= ST_SYSCALL;
        sc_r   <= a_r;
      end else stat_r <= ST_OK;
    end
  end

  assign out_status         = stat_r;
  assign out_syscall_number = sc_r;
  assign out_next_pc        = npc_r;
endmodule

// File: design/stack_vm_instruction_execute_unit.sv
// Top level of the stack machine instruction execute unit.
// Channel | Direction | Handshake          | Fields
// in_     | input     | in_valid/in_stall  | req_type, operand_a, operand_b
// out_    | output    | out_valid/out_stall| status, syscall_number, next_pc
// A request passes from acceptance through read and check, then memory or
// the divider and up to two writeback steps as the opcode needs, to out_valid;
// div and mod go through the one-bit-per-cycle divider. After reset the data
// memory is cleared one word a cycle, over all DATA_WORDS words, while in_stall
// stays high. A stalled result holds the next request off until it is taken.
module stack_vm_instruction_execute_unit import svie_pkg::*; #(
  parameter int NUM_REGS   = NUM_REGS_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int PC_INDEX   = PC_INDEX_DEF,
  parameter int SP_INDEX   = SP_INDEX_DEF,
  parameter int BP_INDEX   = BP_INDEX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_req_type,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_syscall_number,
  output logic signed [31:0] out_next_pc
);
  cmd_t  cmd;
  stat_t st;

  svie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
  );

  svie_dp #(
    .NUM_REGS(NUM_REGS), .DATA_WORDS(DATA_WORDS), .PC_INDEX(PC_INDEX),
    .SP_INDEX(SP_INDEX), .BP_INDEX(BP_INDEX)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_req_type(in_req_type), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .out_status(out_status),
    .out_syscall_number(out_syscall_number), .out_next_pc(out_next_pc)
  );
endmodule
